### design/order_statistic_set_macros.svh
// Assertion macros for the order statistic set checker.
// Used by osset_chk.sv; no other dependencies.
`ifndef ORDER_STATISTIC_SET_MACROS_SVH
`define ORDER_STATISTIC_SET_MACROS_SVH

// Same-cycle implication, masked while reset is asserted
`define OSS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, masked while reset is asserted
`define OSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Condition that must hold on the cycle after reset is seen
`define OSS_ASSERT_AFTER_RST(lbl, clk, rst_n, cons, msg) \
  lbl: assert property (@(posedge clk) !rst_n |=> (cons)) else $error(msg);

`endif

### design/osset_pkg.sv
// Shared types and constants for the order statistic set.
// No dependencies; imported by the top level and the checker.
`default_nettype none

package osset_pkg;

  // Fixed field widths of the request and result words
  localparam int KEY_W  = 10;
  localparam int RANK_W = 11;
  localparam int ANS_W  = 11;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_DELETE = 2'd1,
    REQ_COUNT  = 2'd2,
    REQ_SELECT = 2'd3
  } req_t;

  typedef struct packed {
    req_t              req_type;
    logic [KEY_W-1:0]  key;
    logic [RANK_W-1:0] rank;
  } in_word_t;

  typedef struct packed {
    logic [ANS_W-1:0] answer;
    logic             invalid;
  } out_word_t;

endpackage

`default_nettype wire

### design/osset_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module osset_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### design/order_statistic_set.sv
// Order statistic set: presence counts of keys held in a summing tree in one RAM.
// Insert/delete first reads the leaf and ends there for a repeat, else updates each level;
// count and select walk the tree too (a bad rank ends select at the root); one RAM read per level.
// The result register frees the engine, so the next word is taken while a result waits.
// Reset: synchronous, active low; then a clear pass zeroes every word of the tree RAM,
// with in_stall held high until it is done.
`default_nettype none

module order_statistic_set
  import osset_pkg::*;
#(
  parameter int KEY_BITS = 10
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_word_t  in_word,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_word_t      out_word
);

  localparam int CW    = KEY_BITS + 1;          // count width
  localparam int NW    = KEY_BITS + 1;          // node address width
  localparam int DEPTH = 2 ** NW;
  localparam int XW    = (CW > ANS_W) ? CW : ANS_W;
  localparam int KXW   = (KEY_BITS > KEY_W) ? KEY_BITS : KEY_W;
  localparam int RXW   = (CW > RANK_W) ? CW : RANK_W;

  typedef enum logic [9:0] {
    ST_CLR   = 10'b00_0000_0001,
    ST_IDLE  = 10'b00_0000_0010,
    ST_PRES  = 10'b00_0000_0100,
    ST_PCHK  = 10'b00_0000_1000,
    ST_UPD   = 10'b00_0001_0000,
    ST_CNT   = 10'b00_0010_0000,
    ST_SROOT = 10'b00_0100_0000,
    ST_SCHK  = 10'b00_1000_0000,
    ST_SEL   = 10'b01_0000_0000,
    ST_OUT   = 10'b10_0000_0000
  } state_t;

  state_t              state_r, state_nxt;
  logic [NW-1:0]       node_r, node_nxt;
  logic [KEY_BITS-1:0] key_sh_r, key_sh_nxt;
  logic [RANK_W-1:0]   rank_r, rank_nxt;
  logic [CW-1:0]       k_r, k_nxt;
  logic [CW-1:0]       sum_r, sum_nxt;
  logic                take_r, take_nxt;
  logic                pend_r, pend_nxt;
  logic                set_r, set_nxt;
  logic [NW-1:0]       clr_addr_r, clr_addr_nxt;
  logic [ANS_W-1:0]    res_ans_r, res_ans_nxt;
  logic                res_inv_r, res_inv_nxt;
  logic                out_valid_r;
  out_word_t           out_word_r;
  logic                out_load;

  // RAM ports
  logic          ram_we;
  logic [NW-1:0] ram_waddr;
  logic [CW-1:0] ram_wdata;
  logic [NW-1:0] ram_raddr;
  logic [CW-1:0] ram_rdata;

  // Helpers for width changes
  logic [KXW-1:0]      key_x;
  logic [KEY_BITS-1:0] key_in;
  logic [RXW-1:0]      rank_x;
  logic [RXW-1:0]      pop_x;
  logic [XW-1:0]       ans_x;
  logic [CW-1:0]       add_val;
  logic                go_left;

  assign key_x  = KXW'(in_word.key);
  assign key_in = key_x[KEY_BITS-1:0];
  assign rank_x = RXW'(rank_r);
  assign pop_x  = RXW'(ram_rdata);

  osset_ram #(
    .WIDTH (CW),
    .DEPTH (DEPTH)
  ) u_tree_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_stall = (state_r != ST_IDLE);

  // Sequencer: walks the tree one level per RAM access
  always_comb begin
    state_nxt    = state_r;
    node_nxt     = node_r;
    key_sh_nxt   = key_sh_r;
    rank_nxt     = rank_r;
    k_nxt        = k_r;
    sum_nxt      = sum_r;
    take_nxt     = take_r;
    pend_nxt     = pend_r;
    set_nxt      = set_r;
    clr_addr_nxt = clr_addr_r;
    res_ans_nxt  = res_ans_r;
    res_inv_nxt  = res_inv_r;
    out_load     = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = node_r;
    ram_wdata    = ram_rdata;
    ram_raddr    = '0;
    ans_x        = '0;
    add_val      = '0;
    go_left      = 1'b0;

    unique case (state_r)
      // zero the whole tree after reset
      ST_CLR: begin
        ram_we       = 1'b1;
        ram_waddr    = clr_addr_r;
        ram_wdata    = '0;
        clr_addr_nxt = clr_addr_r + NW'(1);
        if (&clr_addr_r) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_valid) begin
          node_nxt   = NW'(1);
          key_sh_nxt = key_in;
          rank_nxt   = in_word.rank;
          set_nxt    = (in_word.req_type == REQ_INSERT);
          sum_nxt    = '0;
          pend_nxt   = 1'b0;
          unique case (in_word.req_type)
            REQ_INSERT, REQ_DELETE: state_nxt = ST_PRES;
            REQ_COUNT:              state_nxt = ST_CNT;
            REQ_SELECT:             state_nxt = ST_SROOT;
            default:                state_nxt = ST_IDLE;
          endcase
        end
      end

      // read the leaf to see whether the presence changes
      ST_PRES: begin
        ram_raddr = {1'b1, key_sh_r};
        state_nxt = ST_PCHK;
      end

      ST_PCHK: begin
        if ((ram_rdata != '0) == set_r) begin
          state_nxt = ST_IDLE;
        end else begin
          ram_raddr = NW'(1);
          state_nxt = ST_UPD;
        end
      end

      // root to leaf: add or remove one at each node on the key's path
      ST_UPD: begin
        ram_we    = 1'b1;
        ram_waddr = node_r;
        ram_wdata = set_r ? (ram_rdata + CW'(1)) : (ram_rdata - CW'(1));
        if (node_r[KEY_BITS]) begin
          state_nxt = ST_IDLE;
        end else begin
          node_nxt   = {node_r[KEY_BITS-1:0], key_sh_r[KEY_BITS-1]};
          key_sh_nxt = key_sh_r << 1;
          ram_raddr  = {node_r[KEY_BITS-1:0], key_sh_r[KEY_BITS-1]};
        end
      end

      // count below: add each left sibling where the key goes right
      ST_CNT: begin
        if (pend_r && take_r) begin
          add_val = ram_rdata;
        end
        sum_nxt = sum_r + add_val;
        if (!node_r[KEY_BITS]) begin
          ram_raddr  = {node_r[KEY_BITS-1:0], 1'b0};
          take_nxt   = key_sh_r[KEY_BITS-1];
          node_nxt   = {node_r[KEY_BITS-1:0], key_sh_r[KEY_BITS-1]};
          key_sh_nxt = key_sh_r << 1;
          pend_nxt   = 1'b1;
        end else begin
          pend_nxt    = 1'b0;
          ans_x       = XW'(sum_nxt);
          res_ans_nxt = ans_x[ANS_W-1:0];
          res_inv_nxt = 1'b0;
          state_nxt   = ST_OUT;
        end
      end

      // select: check rank against the population at the root
      ST_SROOT: begin
        ram_raddr = NW'(1);
        state_nxt = ST_SCHK;
      end

      ST_SCHK: begin
        if ((rank_r == '0) || (rank_x > pop_x)) begin
          res_ans_nxt = '0;
          res_inv_nxt = 1'b1;
          state_nxt   = ST_OUT;
        end else begin
          k_nxt     = rank_x[CW-1:0];
          ram_raddr = {node_r[KEY_BITS-1:0], 1'b0};
          state_nxt = ST_SEL;
        end
      end

      // descend by the left child's count
      ST_SEL: begin
        go_left  = (ram_rdata >= k_r);
        node_nxt = {node_r[KEY_BITS-1:0], !go_left};
        if (!go_left) begin
          k_nxt = k_r - ram_rdata;
        end
        if (node_nxt[KEY_BITS]) begin
          ans_x       = XW'(node_nxt[KEY_BITS-1:0]);
          res_ans_nxt = ans_x[ANS_W-1:0];
          res_inv_nxt = 1'b0;
          state_nxt   = ST_OUT;
        end else begin
          ram_raddr = {node_nxt[KEY_BITS-1:0], 1'b0};
        end
      end

      // hand the result to the output register once it is free
      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_addr_r  <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
      pend_r     <= pend_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    node_r    <= node_nxt;
    key_sh_r  <= key_sh_nxt;
    rank_r    <= rank_nxt;
    k_r       <= k_nxt;
    sum_r     <= sum_nxt;
    take_r    <= take_nxt;
    set_r     <= set_nxt;
    res_ans_r <= res_ans_nxt;
    res_inv_r <= res_inv_nxt;
    if (out_load) begin
      out_word_r.answer  <= res_ans_r;
      out_word_r.invalid <= res_inv_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

`default_nettype wire

### design/osset_chk.sv
// Port-level checker for the order statistic set, bound to the top level.
// Depends on osset_pkg and order_statistic_set_macros.svh.
`default_nettype none
`include "order_statistic_set_macros.svh"

module osset_chk
  import osset_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_stall,
  input wire in_word_t  in_word,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_word_t out_word
);

  // a stalled result holds its word
  `OSS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_word), "result word changed while stalled")

  // an invalid select carries a zero answer
  `OSS_ASSERT_NOW(a_inv_zero, clk, rst_n, out_valid && out_word.invalid, out_word.answer == '0, "invalid result with nonzero answer")

  // one request at a time: the engine is busy right after taking a word
  `OSS_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall, "input taken on back-to-back cycles")

  // reset starts the clear pass and empties the result register
  `OSS_ASSERT_AFTER_RST(a_reset_state, clk, rst_n, in_stall && !out_valid, "not stalled or result pending after reset")

endmodule

bind order_statistic_set osset_chk u_osset_chk (.*);

`default_nettype wire
